/* src/ll1c_pkg.sv */
// ----------------------------------------------------------------------------
// ll1c_pkg
// Shared types, symbol codes and decode helpers for the LL(1) syntax checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ll1c_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int LEVEL_W     = 7;
	localparam int STATUS_W    = 3;
	localparam int OUT_W       = 16;
	localparam int STEP_W      = 3;
	localparam int MAX_STEPS   = 4;

	typedef enum logic [3:0] {
		SYM_END  = 4'd0,
		SYM_S    = 4'd1,
		SYM_X    = 4'd2,
		SYM_Y    = 4'd3,
		SYM_Z    = 4'd4,
		SYM_A    = 4'd5,
		SYM_B    = 4'd6,
		SYM_MUL  = 4'd7,
		SYM_SUB  = 4'd8,
		SYM_ADD  = 4'd9,
		SYM_LP   = 4'd10,
		SYM_RP   = 4'd11,
		SYM_NONE = 4'd15
	} sym_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_ACCEPT   = 3'd1,
		ST_SYNTAX   = 3'd2,
		ST_INVALID  = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		ACT_MATCH,
		ACT_EXPAND,
		ACT_EPSILON,
		ACT_SYNTAX,
		ACT_OVERFLOW
	} act_t;

	typedef struct packed {
		logic restart;
		logic load;
		logic commit;
		logic push2;
		logic fill;
	} dp_cmd_t;

	typedef struct packed {
		act_t            act;
		logic            push2;
		logic            at_bottom;
		logic [SP_W-1:0] level;
	} dp_sts_t;

	function automatic sym_t char_code(input logic [7:0] c);
		sym_t s;
		unique case (c)
			8'h28:   s = SYM_LP;
			8'h29:   s = SYM_RP;
			8'h2A:   s = SYM_MUL;
			8'h2D:   s = SYM_SUB;
			8'h2B:   s = SYM_ADD;
			8'h61:   s = SYM_A;
			8'h62:   s = SYM_B;
			default: s = SYM_NONE;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

/* src/ll1c_dp.sv */
// ----------------------------------------------------------------------------
// ll1c_dp
// Symbol stack datapath: cached top, stack memory, expansion table.
// ----------------------------------------------------------------------------
`default_nettype none

module ll1c_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ll1c_pkg::dp_cmd_t cmd,
	input  wire ll1c_pkg::sym_t    term,
	output ll1c_pkg::dp_sts_t      sts
);
	import ll1c_pkg::*;

	sym_t              stack_mem [STACK_DEPTH];
	sym_t              top_q;
	logic [SP_W-1:0]   sp_q;
	sym_t              term_q;
	sym_t              pend_q;
	logic [ADDR_W-1:0] pend_addr_q;
	sym_t              rd_q;
	logic              rd_zero_q;

	act_t              act;
	logic [1:0]        n;
	sym_t              rhs0, rhs1, rhs2, wdata;
	logic [SP_W:0]     grow;
	logic [SP_W-1:0]   sp_m1, sp_m2;
	logic [ADDR_W-1:0] wr_addr, rd_addr;

	assign sp_m1   = sp_q - SP_W'(1);
	assign sp_m2   = sp_q - SP_W'(2);
	assign wr_addr = sp_m1[ADDR_W-1:0];
	assign rd_addr = sp_m2[ADDR_W-1:0];
	assign grow    = {1'b0, sp_q} + (SP_W+1)'(n) - (SP_W+1)'(1);
	assign wdata   = (n == 2'd3) ? rhs2 : rhs1;

	always_comb begin
		act  = ACT_SYNTAX;
		n    = 2'd0;
		rhs0 = SYM_END;
		rhs1 = SYM_END;
		rhs2 = SYM_END;
		unique case (top_q)
			SYM_END: act = ACT_SYNTAX;
			SYM_S: begin
				if (term_q == SYM_LP) begin
					act  = ACT_EXPAND;
					n    = 2'd3;
					rhs0 = SYM_LP;
					rhs1 = SYM_X;
					rhs2 = SYM_RP;
				end
			end
			SYM_X: begin
				if (term_q == SYM_LP || term_q == SYM_A || term_q == SYM_B) begin
					act  = ACT_EXPAND;
					n    = 2'd2;
					rhs0 = SYM_Y;
					rhs1 = SYM_Z;
				end
			end
			SYM_Y: begin
				if (term_q == SYM_LP) begin
					act  = ACT_EXPAND;
					n    = 2'd1;
					rhs0 = SYM_S;
				end else if (term_q == SYM_A || term_q == SYM_B) begin
					act  = ACT_EXPAND;
					n    = 2'd1;
					rhs0 = term_q;
				end
			end
			SYM_Z: begin
				if (term_q == SYM_RP) begin
					act = ACT_EPSILON;
				end else if (term_q == SYM_MUL || term_q == SYM_SUB || term_q == SYM_ADD) begin
					act  = ACT_EXPAND;
					n    = 2'd2;
					rhs0 = term_q;
					rhs1 = SYM_X;
				end
			end
			SYM_A, SYM_B, SYM_MUL, SYM_SUB, SYM_ADD, SYM_LP, SYM_RP: begin
				act = (top_q == term_q) ? ACT_MATCH : ACT_SYNTAX;
			end
			default: act = ACT_SYNTAX;
		endcase
		if (act == ACT_EXPAND && grow > (SP_W+1)'(STACK_DEPTH))
			act = ACT_OVERFLOW;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= SYM_S;
			sp_q  <= SP_W'(2);
		end else if (cmd.restart) begin
			top_q <= SYM_S;
			sp_q  <= SP_W'(2);
		end else if (cmd.commit) begin
			unique case (act)
				ACT_EXPAND: begin
					top_q <= rhs0;
					sp_q  <= grow[SP_W-1:0];
				end
				ACT_MATCH, ACT_EPSILON: sp_q <= sp_m1;
				default: ;
			endcase
		end else if (cmd.fill) begin
			top_q <= rd_zero_q ? SYM_END : rd_q;
		end
	end

	// entry 0 is never written; a read of address 0 yields the bottom marker instead
	always_ff @(posedge clk) begin
		if (cmd.load)
			term_q <= term;
		if (cmd.commit && act == ACT_EXPAND && n != 2'd1)
			stack_mem[wr_addr] <= wdata;
		if (cmd.commit && act == ACT_EXPAND) begin
			pend_q      <= rhs1;
			pend_addr_q <= sp_q[ADDR_W-1:0];
		end
		if (cmd.push2)
			stack_mem[pend_addr_q] <= pend_q;
		rd_q      <= stack_mem[rd_addr];
		rd_zero_q <= (rd_addr == '0);
	end

	assign sts.act       = act;
	assign sts.push2     = (n == 2'd3);
	assign sts.at_bottom = (sp_q == SP_W'(1));
	assign sts.level     = sp_q;

endmodule

`default_nettype wire

/* src/ll1c_ctrl.sv */
// ----------------------------------------------------------------------------
// ll1c_ctrl
// Parser sequencer: input decode, step control, sticky error, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ll1c_ctrl (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [7:0]                      s_tdata,
	input  wire logic                            s_tlast,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output ll1c_pkg::status_t                    m_status,
	output logic [ll1c_pkg::LEVEL_W-1:0]         m_level,
	output ll1c_pkg::dp_cmd_t                    cmd,
	output ll1c_pkg::sym_t                       term,
	input  wire ll1c_pkg::dp_sts_t               sts
);
	import ll1c_pkg::*;

	typedef enum logic [2:0] {
		IDLE,
		EVAL,
		PUSH,
		FILL,
		DONE
	} state_t;

	state_t              state_q;
	status_t             sticky_q;
	status_t             res_q;
	logic [STEP_W-1:0]   step_q;
	logic                fill_last_q;
	logic                accept;
	logic                step_out;

	assign term     = char_code(s_tdata);
	assign s_tready = (state_q == IDLE);
	assign accept   = s_tvalid && s_tready;
	assign step_out = (step_q == STEP_W'(MAX_STEPS));

	assign cmd.restart = accept && s_tlast;
	assign cmd.load    = accept && !s_tlast;
	assign cmd.commit  = (state_q == EVAL) && !step_out;
	assign cmd.push2   = (state_q == PUSH);
	assign cmd.fill    = (state_q == FILL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			sticky_q    <= ST_OK;
			res_q       <= ST_OK;
			step_q      <= '0;
			fill_last_q <= 1'b0;
			m_tvalid    <= 1'b0;
			m_status    <= ST_OK;
			m_level     <= '0;
		end else begin
			if (m_tvalid && m_tready && state_q != DONE)
				m_tvalid <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						step_q <= '0;
						if (s_tlast) begin
							if (sticky_q != ST_OK)
								res_q <= sticky_q;
							else
								res_q <= sts.at_bottom ? ST_ACCEPT : ST_SYNTAX;
							sticky_q <= ST_OK;
							state_q  <= DONE;
						end else if (sticky_q != ST_OK) begin
							res_q   <= sticky_q;
							state_q <= DONE;
						end else if (term == SYM_NONE) begin
							res_q    <= ST_INVALID;
							sticky_q <= ST_INVALID;
							state_q  <= DONE;
						end else begin
							state_q <= EVAL;
						end
					end
				end
				EVAL: begin
					if (step_out) begin
						res_q    <= ST_SYNTAX;
						sticky_q <= ST_SYNTAX;
						state_q  <= DONE;
					end else begin
						unique case (sts.act)
							ACT_MATCH: begin
								fill_last_q <= 1'b1;
								state_q     <= FILL;
							end
							ACT_EPSILON: begin
								fill_last_q <= 1'b0;
								step_q      <= step_q + STEP_W'(1);
								state_q     <= FILL;
							end
							ACT_EXPAND: begin
								step_q  <= step_q + STEP_W'(1);
								state_q <= sts.push2 ? PUSH : EVAL;
							end
							ACT_OVERFLOW: begin
								res_q    <= ST_OVERFLOW;
								sticky_q <= ST_OVERFLOW;
								state_q  <= DONE;
							end
							default: begin
								res_q    <= ST_SYNTAX;
								sticky_q <= ST_SYNTAX;
								state_q  <= DONE;
							end
						endcase
					end
				end
				PUSH: state_q <= EVAL;
				FILL: begin
					if (fill_last_q) begin
						res_q   <= ST_OK;
						state_q <= DONE;
					end else begin
						state_q <= EVAL;
					end
				end
				DONE: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_status <= res_q;
						m_level  <= LEVEL_W'(sts.level);
						state_q  <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* src/ll1_expression_syntax_checker.sv */
// ----------------------------------------------------------------------------
// ll1_expression_syntax_checker
// Streaming LL(1) recognizer for S->(X), X->YZ, Y->S|a|b, Z->*X|-X|+X|empty.
//
//   port group   dir  tdata bits (low first)              tlast
//   s_axis       in   [7:0] symbol                        end_of_string
//   m_axis       out  [2:0] status, [9:3] stack_level     -
//
// Sequencing: an end marker, pending error or invalid character goes from
//   idle straight to the result; otherwise each beat runs stack steps in EVAL,
//   a PUSH state after S->(X) and a FILL state after an empty Z or the match,
//   set by the stack memory's single write port and registered read.
// Reset: stack restarts as bottom marker plus S, no error, no clearing pass.
// Stalls: a held result does not block the next input beat; the next result
//   waits in the sequencer until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module ll1_expression_syntax_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] symbol
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata   // [2:0] status, [9:3] stack_level
);
	import ll1c_pkg::*;

	dp_cmd_t              cmd;
	dp_sts_t              sts;
	sym_t                 term;
	status_t              status;
	logic [LEVEL_W-1:0]   level;

	ll1c_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.s_tdata  (s_axis_tdata),
		.s_tlast  (s_axis_tlast),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_status (status),
		.m_level  (level),
		.cmd      (cmd),
		.term     (term),
		.sts      (sts)
	);

	ll1c_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.term   (term),
		.sts    (sts)
	);

	assign m_axis_tdata = {(OUT_W-LEVEL_W-STATUS_W)'(0), level, status};

endmodule

`default_nettype wire

/* src/ll1c_chk.sv */
// ----------------------------------------------------------------------------
// ll1c_chk
// Port-level checks for the LL(1) syntax checker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ll1c_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [15:0] m_axis_tdata
);
	import ll1c_pkg::*;

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[2:0] <= ST_OVERFLOW)
			&& (m_axis_tdata[9:3] <= LEVEL_W'(STACK_DEPTH))
			&& (m_axis_tdata[15:10] == '0))
		else $error("result beat out of range");

	a_accept_level: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[2:0] == ST_ACCEPT) |-> (m_axis_tdata[9:3] == 7'd2))
		else $error("accept without restarted stack");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result beat changed");

	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted while a beat is in progress");

endmodule

bind ll1_expression_syntax_checker ll1c_chk u_ll1c_chk (.*);

`default_nettype wire
